FILE: rtl/mlr_pkg.sv
// Shared types and constants for the midpoint line rasterizer.
package mlr_pkg;

  // Default coordinate width in bits.
  localparam int unsigned COORD_BITS_DEF = 6;

  // Octant codes, numbered counterclockwise from the shallow positive-x octant.
  localparam logic [2:0] OCT0 = 3'd0;
  localparam logic [2:0] OCT1 = 3'd1;
  localparam logic [2:0] OCT2 = 3'd2;
  localparam logic [2:0] OCT3 = 3'd3;
  localparam logic [2:0] OCT4 = 3'd4;
  localparam logic [2:0] OCT5 = 3'd5;
  localparam logic [2:0] OCT6 = 3'd6;
  localparam logic [2:0] OCT7 = 3'd7;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_RUN   = 3'b100
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;  // capture the endpoints of an accepted command
    logic setup;    // classify the line and load the stepping state
    logic emit;     // load the output beat and advance one pixel
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;     // the current pixel is the end point
  } dp_status_t;

endpackage

FILE: rtl/mlr_ctrl.sv
// Controller state machine of the midpoint line rasterizer.
module mlr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mlr_pkg::dp_cmd_t    cmd_o,
  input  mlr_pkg::dp_status_t status_i
);
  import mlr_pkg::*;

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;
  logic   out_free;

  // The output register can take a new beat when empty or being drained.
  assign out_free = !m_valid_q || out_ready_i;

  // Next-state and command decode.
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    in_ready_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_RUN;
      end
      ST_RUN: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.done) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on a new beat, cleared once the beat is taken.
  always_comb begin
    if (cmd_o.emit) begin
      m_valid_d = 1'b1;
    end else if (out_ready_i) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  assign out_valid_o = m_valid_q;

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

endmodule

FILE: rtl/mlr_dp.sv
// Datapath of the midpoint line rasterizer: octant setup, stepping and output register.
module mlr_dp #(
  parameter int unsigned COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mlr_pkg::dp_cmd_t           cmd_i,
  output mlr_pkg::dp_status_t        status_o,
  input  logic [4*COORD_BITS-1:0]   in_data_i,
  output logic [2*COORD_BITS-1:0]   out_data_o,
  output logic                      out_last_o
);
  import mlr_pkg::*;

  localparam int unsigned W  = COORD_BITS;
  localparam int unsigned CW = COORD_BITS + 1;  // octant-0 coordinates
  localparam int unsigned EW = COORD_BITS + 2;  // east increment
  localparam int unsigned DW = COORD_BITS + 3;  // decision and northeast increment

  // Map a point into octant 0; result is {u, v}.
  function automatic logic [2*CW-1:0] to_oct0(input logic [2:0] o,
                                              input logic signed [CW-1:0] x,
                                              input logic signed [CW-1:0] y);
    logic signed [CW-1:0] u;
    logic signed [CW-1:0] v;
    case (o)
      OCT0:    begin u = x;  v = y;  end
      OCT1:    begin u = y;  v = x;  end
      OCT2:    begin u = y;  v = -x; end
      OCT3:    begin u = -x; v = y;  end
      OCT4:    begin u = -x; v = -y; end
      OCT5:    begin u = -y; v = -x; end
      OCT6:    begin u = -y; v = x;  end
      default: begin u = x;  v = -y; end
    endcase
    return {u, v};
  endfunction

  // Map an octant-0 point back to screen space; result is {x, y}.
  function automatic logic [2*CW-1:0] from_oct0(input logic [2:0] o,
                                                input logic signed [CW-1:0] u,
                                                input logic signed [CW-1:0] v);
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    case (o)
      OCT0:    begin x = u;  y = v;  end
      OCT1:    begin x = v;  y = u;  end
      OCT2:    begin x = -v; y = u;  end
      OCT3:    begin x = -u; y = v;  end
      OCT4:    begin x = -u; y = -v; end
      OCT5:    begin x = -v; y = -u; end
      OCT6:    begin x = v;  y = -u; end
      default: begin x = u;  y = -v; end
    endcase
    return {x, y};
  endfunction

  // Captured endpoints.
  logic signed [W-1:0] x0_q, y0_q, x1_q, y1_q;

  // Stepping state.
  logic signed [CW-1:0] step_major_q, step_major_d;
  logic signed [CW-1:0] step_minor_q, step_minor_d;
  logic signed [CW-1:0] stop_major_q, stop_major_d;
  logic signed [DW-1:0] decision_q, decision_d;
  logic        [EW-1:0] inc_east_q, inc_east_d;
  logic signed [DW-1:0] inc_ne_q, inc_ne_d;
  logic        [2:0]    octant_q, octant_d;

  // Output beat register.
  logic [2*W-1:0] out_data_q;
  logic           out_last_q;

  // Setup signals.
  logic signed [CW-1:0] x0e, y0e, x1e, y1e;
  logic signed [CW-1:0] dx, dy, adx_full, ady_full;
  logic        [W-1:0]  adx, ady;
  logic                 xmaj;
  logic        [2:0]    oct_new;
  logic        [2*CW-1:0] p0, p1;
  logic signed [CW-1:0] u0, v0, u1, v1, du, dv;
  logic signed [DW-1:0] du_w, dv_w;

  // Stepping signals.
  logic                 done;
  logic        [2*CW-1:0] pix;
  logic signed [CW-1:0] pix_x, pix_y;

  // Endpoint capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x0_q <= in_data_i[0*W +: W];
      y0_q <= in_data_i[1*W +: W];
      x1_q <= in_data_i[2*W +: W];
      y1_q <= in_data_i[3*W +: W];
    end
  end

  // Octant classification from the signs and magnitudes of dx and dy.
  always_comb begin
    x0e      = CW'(x0_q);
    y0e      = CW'(y0_q);
    x1e      = CW'(x1_q);
    y1e      = CW'(y1_q);
    dx       = x1e - x0e;
    dy       = y1e - y0e;
    adx_full = dx[CW-1] ? -dx : dx;
    ady_full = dy[CW-1] ? -dy : dy;
    adx      = adx_full[W-1:0];
    ady      = ady_full[W-1:0];
    xmaj     = adx >= ady;
    case ({dx[CW-1], dy[CW-1]})
      2'b00:   oct_new = xmaj ? OCT0 : OCT1;
      2'b10:   oct_new = xmaj ? OCT3 : OCT2;
      2'b11:   oct_new = xmaj ? OCT4 : OCT5;
      default: oct_new = xmaj ? OCT7 : OCT6;
    endcase
  end

  // Endpoints in octant 0 and the initial decision terms.
  always_comb begin
    p0   = to_oct0(oct_new, x0e, y0e);
    p1   = to_oct0(oct_new, x1e, y1e);
    u0   = p0[CW +: CW];
    v0   = p0[0 +: CW];
    u1   = p1[CW +: CW];
    v1   = p1[0 +: CW];
    du   = u1 - u0;
    dv   = v1 - v0;
    du_w = DW'(du);
    dv_w = DW'(dv);
  end

  // The current pixel is the last one once the major axis reaches the end point.
  assign done          = step_major_q >= stop_major_q;
  assign status_o.done = done;

  // Next stepping state: load on setup, advance one pixel on emit.
  always_comb begin
    step_major_d = step_major_q;
    step_minor_d = step_minor_q;
    stop_major_d = stop_major_q;
    decision_d   = decision_q;
    inc_east_d   = inc_east_q;
    inc_ne_d     = inc_ne_q;
    octant_d     = octant_q;
    if (cmd_i.setup) begin
      step_major_d = u0;
      step_minor_d = v0;
      stop_major_d = u1;
      decision_d   = (dv_w <<< 1) - du_w;
      inc_east_d   = unsigned'(EW'(dv)) << 1;
      inc_ne_d     = (dv_w - du_w) <<< 1;
      octant_d     = oct_new;
    end else if (cmd_i.emit && !done) begin
      // A tie at zero takes the diagonal step.
      if (decision_q[DW-1]) begin
        decision_d = decision_q + signed'({1'b0, inc_east_q});
      end else begin
        step_minor_d = step_minor_q + CW'(1);
        decision_d   = decision_q + inc_ne_q;
      end
      step_major_d = step_major_q + CW'(1);
    end
  end

  // Stepping state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_major_q <= '0;
      step_minor_q <= '0;
      stop_major_q <= '0;
      decision_q   <= '0;
      inc_east_q   <= '0;
      inc_ne_q     <= '0;
      octant_q     <= OCT0;
    end else begin
      step_major_q <= step_major_d;
      step_minor_q <= step_minor_d;
      stop_major_q <= stop_major_d;
      decision_q   <= decision_d;
      inc_east_q   <= inc_east_d;
      inc_ne_q     <= inc_ne_d;
      octant_q     <= octant_d;
    end
  end

  // Map the current pixel back to screen space.
  always_comb begin
    pix   = from_oct0(octant_q, step_major_q, step_minor_q);
    pix_x = pix[CW +: CW];
    pix_y = pix[0 +: CW];
  end

  // Output beat register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= {pix_y[W-1:0], pix_x[W-1:0]};
      out_last_q <= done;
    end
  end

  assign out_data_o = out_data_q;
  assign out_last_o = out_last_q;

endmodule

FILE: rtl/midpoint_line_rasterizer.sv
// Top level of the eight-octant midpoint line rasterizer.
//
// Each input beat is a line command with two signed endpoints; the block
// answers with 1 + max(|dx|, |dy|) pixel beats, walking from the start point
// to the end point, and marks the end point with tlast. After a command is
// accepted, the block captures it in the endpoint registers, then classifies
// the octant and loads the decision terms in a setup state; then the stepper
// delivers one pixel per cycle while the output side takes beats. The single
// decision update per pixel sets that rate. The next command is taken as soon
// as the last pixel has moved into the output register. A zero-length line
// gives a single pixel with tlast set.
module midpoint_line_rasterizer #(
  parameter int unsigned COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // Fields from bit 0 up: start_x, start_y, end_x, end_y, zero padding.
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]         s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // Fields from bit 0 up: pixel_x, pixel_y, zero padding.
  output logic [((2*COORD_BITS+7)/8)*8-1:0]         m_axis_tdata,
  // last_pixel.
  output logic                                      m_axis_tlast
);
  import mlr_pkg::*;

  localparam int unsigned OUT_TDATA_W = ((2*COORD_BITS+7)/8)*8;

  dp_cmd_t               cmd;
  dp_status_t            status;
  logic [2*COORD_BITS-1:0] out_data;

  // Control.
  mlr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Datapath.
  mlr_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (s_axis_tdata[4*COORD_BITS-1:0]),
    .out_data_o (out_data),
    .out_last_o (m_axis_tlast)
  );

  // Pad the pixel fields to whole bytes.
  assign m_axis_tdata = OUT_TDATA_W'(out_data);

endmodule

FILE: rtl/mlr_chk.sv
// Port-level checks for the midpoint line rasterizer, bound to the top level.
module mlr_chk #(
  parameter int unsigned COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  // Fields from bit 0 up: start_x, start_y, end_x, end_y, zero padding.
  input logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  // Fields from bit 0 up: pixel_x, pixel_y, zero padding.
  input logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  // last_pixel.
  input logic                              m_axis_tlast
);

  // A stalled output beat keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // A command beat that waits for the block keeps its payload.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("input beat changed while waiting");

  // After a command is taken the input side closes for setup.
  a_in_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready stayed high after a command beat");

  // While a pixel other than the last waits, no new command is taken.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input ready high while a line is in progress");

  // The input side reopens only with the last pixel of the line on the output.
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_axis_tready) |-> m_axis_tvalid && m_axis_tlast)
    else $error("input ready rose without a final pixel beat");

endmodule

bind midpoint_line_rasterizer mlr_chk #(
  .COORD_BITS (COORD_BITS)
) u_mlr_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
